// ===== src/pmlm_pkg.sv =====
// Shared types and constants for the pooled multi-list manager.
package pmlm_pkg;

    localparam int DEF_NUM_LISTS = 16;
    localparam int DEF_NUM_NODES = 256;
    localparam int DEF_ITEM_BITS = 32;
    localparam int CMD_BITS      = 4;
    localparam int STATUS_BITS   = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CREATE, CMD_COUNT, CMD_FIRST, CMD_LAST,
        CMD_NEXT, CMD_PREV, CMD_CURR, CMD_ADD,
        CMD_INSERT, CMD_APPEND, CMD_PREPEND, CMD_REMOVE,
        CMD_CONCAT, CMD_FREE, CMD_TRIM, CMD_SEARCH
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK, STAT_MISS, STAT_FULL
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_DISP, S_RD_NEXT, S_RD_PREV, S_ITEM, S_NX, S_PV,
        S_POS, S_PL0, S_PL1, S_PL2, S_PL3, S_PL4, S_UL1, S_UL2, S_UL3, S_TR,
        S_CC1, S_CC2, S_CC3, S_CC4, S_CC5, S_CC6, S_SR, S_CR1, S_CR2, S_CR3,
        S_DONE
    } state_t;

    typedef struct packed {
        logic we_next;
        logic we_prev;
        logic we_item;
    } node_we_t;

endpackage

// ===== src/pooled_multi_list_manager_unit.sv =====
// Top level of the pooled multi-list manager: command sequencer, list table and free stacks.
// One transaction is in flight at a time; the next is accepted once the sequencer is back in
// idle after the result is loaded; a held result lets one more transaction run.
// Reset is asynchronous; free node and list chains come from fill marks, no clearing pass.
module pooled_multi_list_manager_unit #(
    parameter int NUM_LISTS = pmlm_pkg::DEF_NUM_LISTS,
    parameter int NUM_NODES = pmlm_pkg::DEF_NUM_NODES,
    parameter int ITEM_BITS = pmlm_pkg::DEF_ITEM_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [pmlm_pkg::CMD_BITS-1:0]        cmd,
    input  logic [$clog2(NUM_LISTS)-1:0]         list_sel,
    input  logic [$clog2(NUM_LISTS)-1:0]         second_list,
    input  logic [ITEM_BITS-1:0]                 item_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pmlm_pkg::STATUS_BITS-1:0]     status,
    output logic [ITEM_BITS-1:0]                 item_out,
    output logic [$clog2(NUM_LISTS)-1:0]         new_list,
    output logic [$clog2(NUM_NODES+1)-1:0]       item_count
);
    import pmlm_pkg::*;

    localparam int LA = $clog2(NUM_LISTS);
    localparam int LP = $clog2(NUM_LISTS+1);
    localparam int AW = $clog2(NUM_NODES);
    localparam int PW = $clog2(NUM_NODES+1);
    localparam logic [PW-1:0] NIL_N = PW'(NUM_NODES);
    localparam logic [LP-1:0] NIL_L = LP'(NUM_LISTS);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [LA-1:0] l_reg, l_next, l2_reg, l2_next, ladr_reg, ladr_next, made_reg, made_next;
    logic [ITEM_BITS-1:0] v_reg, v_next, item_reg, item_next;
    logic [AW-1:0] h_reg, h_next, t_reg, t_next, c_reg, c_next, n_reg, n_next, t2_reg, t2_next;
    logic [PW-1:0] len_reg, len_next, a_reg, a_next, b_reg, b_next;
    status_t st_reg, st_next;
    logic wlt_reg, wlt_next;
    logic [LP-1:0] lnk_reg, lnk_next;
    logic [PW-1:0] ft_reg, ft_next, wm_reg, wm_next;
    logic [LP-1:0] flt_reg, flt_next, lwm_reg, lwm_next;
    logic [NUM_LISTS-1:0] used_reg, used_next;
    logic ov_reg, ov_next;
    status_t ostat_reg, ostat_next;
    logic [ITEM_BITS-1:0] oitem_reg, oitem_next;
    logic [LA-1:0] onew_reg, onew_next;
    logic [PW-1:0] ocnt_reg, ocnt_next;

    // list table and free list link memories
    logic [AW-1:0] lt_head [NUM_LISTS];
    logic [AW-1:0] lt_tail [NUM_LISTS];
    logic [AW-1:0] lt_cur  [NUM_LISTS];
    logic [PW-1:0] lt_len  [NUM_LISTS];
    logic [LP-1:0] lnk_mem [NUM_LISTS];
    logic [AW-1:0] lt_h_q, lt_t_q, lt_c_q;
    logic [PW-1:0] lt_len_q;
    logic [LP-1:0] lk_q, lk_top_q, lnk_rd;
    logic lk_fresh_q;
    logic [LA-1:0] lt_raddr, lnk_waddr;
    logic lt_we, lnk_we;

    // node memory port
    logic [AW-1:0] nrd_addr, nwr_addr;
    node_we_t nwe;
    logic [PW-1:0] nwd_next, nwd_prev, nd_next, nd_prev;
    logic [ITEM_BITS-1:0] nd_item;

    logic lok, ok, l2ok, nl_ok, out_load;
    logic [LP-1:0] nl;

    pmlm_node_mem #(
        .NUM_NODES (NUM_NODES),
        .ITEM_BITS (ITEM_BITS)
    ) u_node_mem (
        .clk       (clk),
        .rd_addr   (nrd_addr),
        .fill_mark (wm_reg),
        .we        (nwe),
        .wr_addr   (nwr_addr),
        .wr_next   (nwd_next),
        .wr_prev   (nwd_prev),
        .wr_item   (v_reg),
        .rd_next   (nd_next),
        .rd_prev   (nd_prev),
        .rd_item   (nd_item)
    );

    always_ff @(posedge clk)
    begin
        if (lt_we)
        begin
            lt_head[ladr_reg] <= h_reg;
            lt_tail[ladr_reg] <= t_reg;
            lt_cur[ladr_reg]  <= c_reg;
            lt_len[ladr_reg]  <= len_reg;
        end
        if (lnk_we)
        begin
            lnk_mem[lnk_waddr] <= flt_reg;
        end
        lt_h_q     <= lt_head[lt_raddr];
        lt_t_q     <= lt_tail[lt_raddr];
        lt_c_q     <= lt_cur[lt_raddr];
        lt_len_q   <= lt_len[lt_raddr];
        lk_q       <= lnk_mem[LA'(flt_reg)];
        lk_top_q   <= flt_reg;
        lk_fresh_q <= flt_reg >= lwm_reg;
    end

    assign lnk_rd = lk_fresh_q ? lk_top_q + LP'(1) : lk_q;

    assign lok   = LP'(l_reg) < NIL_L;
    assign ok    = lok && used_reg[l_reg];
    assign l2ok  = (LP'(l2_reg) < NIL_L) && (l2_reg != l_reg) && used_reg[l2_reg];
    assign nl    = used_reg[0] ? flt_reg : '0;
    assign nl_ok = !used_reg[0] || (flt_reg != NIL_L);
    assign out_load = (state_reg == S_DONE) && (!ov_reg || out_ready);

    // next state and register updates
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        l_next     = l_reg;
        l2_next    = l2_reg;
        ladr_next  = ladr_reg;
        made_next  = made_reg;
        v_next     = v_reg;
        item_next  = item_reg;
        h_next     = h_reg;
        t_next     = t_reg;
        c_next     = c_reg;
        n_next     = n_reg;
        t2_next    = t2_reg;
        len_next   = len_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        st_next    = st_reg;
        wlt_next   = wlt_reg;
        lnk_next   = lnk_reg;
        ft_next    = ft_reg;
        wm_next    = wm_reg;
        flt_next   = flt_reg;
        lwm_next   = lwm_reg;
        used_next  = used_reg;
        ov_next    = ov_reg && !out_ready;
        ostat_next = ostat_reg;
        oitem_next = oitem_reg;
        onew_next  = onew_reg;
        ocnt_next  = ocnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(cmd);
                    l_next     = list_sel;
                    l2_next    = second_list;
                    v_next     = item_value;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                h_next     = lt_h_q;
                t_next     = lt_t_q;
                c_next     = lt_c_q;
                len_next   = lt_len_q;
                lnk_next   = lnk_rd;
                ladr_next  = l_reg;
                st_next    = STAT_MISS;
                item_next  = '0;
                made_next  = '0;
                wlt_next   = 1'b0;
                state_next = S_DISP;
            end
            S_DISP:
            begin
                state_next = S_DONE;
                if (cmd_reg == CMD_CREATE)
                begin
                    if (!nl_ok || ft_reg == NIL_N)
                    begin
                        st_next = STAT_FULL;
                    end
                    else
                    begin
                        state_next = S_CR1;
                    end
                end
                else if (ok)
                begin
                    wlt_next = 1'b1;
                    case (cmd_reg)
                        CMD_COUNT:
                        begin
                            st_next = STAT_OK;
                        end
                        CMD_FIRST, CMD_LAST:
                        begin
                            if (len_reg == '0)
                            begin
                                c_next = h_reg;
                            end
                            else
                            begin
                                state_next = (cmd_reg == CMD_FIRST) ? S_RD_NEXT : S_RD_PREV;
                            end
                        end
                        CMD_NEXT:
                        begin
                            state_next = S_NX;
                        end
                        CMD_PREV:
                        begin
                            state_next = S_PV;
                        end
                        CMD_CURR:
                        begin
                            if (c_reg != h_reg && c_reg != t_reg)
                            begin
                                state_next = S_ITEM;
                            end
                        end
                        CMD_ADD:
                        begin
                            if (c_reg == t_reg)
                            begin
                                state_next = S_POS;
                            end
                            else
                            begin
                                a_next     = PW'(c_reg);
                                state_next = S_PL0;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (c_reg == h_reg)
                            begin
                                a_next     = PW'(h_reg);
                                state_next = S_PL0;
                            end
                            else
                            begin
                                state_next = S_POS;
                            end
                        end
                        CMD_APPEND:
                        begin
                            state_next = S_POS;
                        end
                        CMD_PREPEND:
                        begin
                            a_next     = PW'(h_reg);
                            state_next = S_PL0;
                        end
                        CMD_REMOVE:
                        begin
                            if (len_reg != '0 && c_reg != h_reg && c_reg != t_reg)
                            begin
                                n_next     = c_reg;
                                state_next = S_UL1;
                            end
                        end
                        CMD_TRIM:
                        begin
                            if (len_reg != '0)
                            begin
                                state_next = S_TR;
                            end
                        end
                        CMD_CONCAT:
                        begin
                            if (l2ok)
                            begin
                                state_next = S_CC1;
                            end
                        end
                        CMD_FREE:
                        begin
                            ft_next          = PW'(h_reg);
                            len_next         = '0;
                            used_next[l_reg] = 1'b0;
                            if (l_reg != '0)
                            begin
                                flt_next = LP'(l_reg);
                            end
                            st_next = STAT_OK;
                        end
                        CMD_SEARCH:
                        begin
                            if (len_reg != '0 && c_reg != t_reg)
                            begin
                                state_next = S_SR;
                            end
                        end
                        default:
                        begin
                            st_next = STAT_MISS;
                        end
                    endcase
                end
            end
            S_RD_NEXT:
            begin
                c_next     = AW'(nd_next);
                state_next = S_ITEM;
            end
            S_RD_PREV:
            begin
                c_next     = AW'(nd_prev);
                state_next = S_ITEM;
            end
            S_ITEM:
            begin
                item_next  = nd_item;
                st_next    = STAT_OK;
                state_next = S_DONE;
            end
            S_NX:
            begin
                if (c_reg == t_reg || PW'(c_reg) == nd_prev)
                begin
                    c_next     = t_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD_NEXT;
                end
            end
            S_PV:
            begin
                if (c_reg == h_reg || PW'(c_reg) == nd_next)
                begin
                    c_next     = h_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD_PREV;
                end
            end
            S_POS:
            begin
                a_next     = nd_prev;
                state_next = S_PL0;
            end
            S_PL0:
            begin
                if (ft_reg == NIL_N)
                begin
                    st_next    = STAT_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    n_next     = AW'(ft_reg);
                    state_next = S_PL1;
                end
            end
            S_PL1:
            begin
                ft_next = nd_next;
                if (PW'(n_reg) == wm_reg)
                begin
                    wm_next = wm_reg + PW'(1);
                end
                state_next = S_PL2;
            end
            S_PL2:
            begin
                b_next     = nd_next;
                state_next = S_PL3;
            end
            S_PL3:
            begin
                state_next = S_PL4;
            end
            S_PL4:
            begin
                c_next     = n_reg;
                len_next   = len_reg + PW'(1);
                item_next  = v_reg;
                st_next    = STAT_OK;
                state_next = S_DONE;
            end
            S_TR:
            begin
                n_next     = AW'(nd_prev);
                state_next = S_UL1;
            end
            S_UL1:
            begin
                a_next     = nd_prev;
                b_next     = nd_next;
                item_next  = nd_item;
                c_next     = (cmd_reg == CMD_TRIM) ? AW'(nd_prev) : AW'(nd_next);
                state_next = S_UL2;
            end
            S_UL2:
            begin
                state_next = S_UL3;
            end
            S_UL3:
            begin
                ft_next    = PW'(n_reg);
                len_next   = len_reg - PW'(1);
                st_next    = STAT_OK;
                state_next = S_DONE;
            end
            S_CC1:
            begin
                n_next     = lt_h_q;
                t2_next    = lt_t_q;
                len_next   = len_reg + lt_len_q;
                state_next = S_CC2;
            end
            S_CC2:
            begin
                a_next     = nd_prev;
                state_next = S_CC3;
            end
            S_CC3:
            begin
                b_next     = nd_next;
                state_next = S_CC4;
            end
            S_CC4:
            begin
                state_next = S_CC5;
            end
            S_CC5:
            begin
                ft_next = PW'(t_reg);
                if (c_reg == t_reg)
                begin
                    c_next = t2_reg;
                end
                t_next     = t2_reg;
                state_next = S_CC6;
            end
            S_CC6:
            begin
                ft_next           = PW'(n_reg);
                used_next[l2_reg] = 1'b0;
                if (l2_reg != '0)
                begin
                    flt_next = LP'(l2_reg);
                end
                st_next    = STAT_OK;
                state_next = S_DONE;
            end
            S_SR:
            begin
                if (c_reg != h_reg && nd_item == v_reg)
                begin
                    item_next  = nd_item;
                    st_next    = STAT_OK;
                    state_next = S_DONE;
                end
                else if (nd_next != PW'(t_reg) && nd_next != NIL_N)
                begin
                    c_next = AW'(nd_next);
                end
                else
                begin
                    c_next     = t_reg;
                    state_next = S_DONE;
                end
            end
            S_CR1:
            begin
                if (nd_next == NIL_N)
                begin
                    st_next    = STAT_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    h_next = AW'(ft_reg);
                    c_next = AW'(ft_reg);
                    t_next = AW'(nd_next);
                    if (ft_reg == wm_reg)
                    begin
                        wm_next = wm_reg + PW'(1);
                    end
                    if (used_reg[0])
                    begin
                        flt_next = lnk_reg;
                        if (flt_reg == lwm_reg)
                        begin
                            lwm_next = lwm_reg + LP'(1);
                        end
                    end
                    ladr_next  = LA'(nl);
                    made_next  = LA'(nl);
                    state_next = S_CR2;
                end
            end
            S_CR2:
            begin
                ft_next = nd_next;
                if (PW'(t_reg) == wm_reg)
                begin
                    wm_next = wm_reg + PW'(1);
                end
                state_next = S_CR3;
            end
            S_CR3:
            begin
                used_next[ladr_reg] = 1'b1;
                len_next            = '0;
                wlt_next            = 1'b1;
                st_next             = STAT_OK;
                state_next          = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    ov_next    = 1'b1;
                    ostat_next = st_reg;
                    oitem_next = (st_reg == STAT_OK) ? item_reg : '0;
                    onew_next  = made_reg;
                    ocnt_next  = (cmd_reg != CMD_CREATE && ok) ? len_reg : '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory controls and handshake
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        lt_raddr  = (state_reg == S_DISP) ? l2_reg : list_sel;
        lt_we     = out_load && wlt_reg;
        lnk_we    = 1'b0;
        lnk_waddr = l_reg;
        nrd_addr  = c_reg;
        nwr_addr  = n_reg;
        nwe       = '0;
        nwd_next  = ft_reg;
        nwd_prev  = a_reg;

        unique case (state_reg)
            S_DISP:
            begin
                case (cmd_reg)
                    CMD_CREATE:                  nrd_addr = AW'(ft_reg);
                    CMD_FIRST, CMD_PREV:         nrd_addr = h_reg;
                    CMD_LAST, CMD_NEXT, CMD_ADD,
                    CMD_APPEND, CMD_TRIM:        nrd_addr = t_reg;
                    default:                     nrd_addr = c_reg;
                endcase
                if (ok && cmd_reg == CMD_FREE)
                begin
                    nwr_addr    = t_reg;
                    nwe.we_next = 1'b1;
                    nwd_next    = ft_reg;
                    lnk_we      = (l_reg != '0);
                    lnk_waddr   = l_reg;
                end
            end
            S_RD_NEXT, S_SR, S_CR1:
            begin
                nrd_addr = AW'(nd_next);
            end
            S_RD_PREV, S_TR:
            begin
                nrd_addr = AW'(nd_prev);
            end
            S_PL0:
            begin
                nrd_addr = AW'(ft_reg);
            end
            S_PL1:
            begin
                nrd_addr = AW'(a_reg);
            end
            S_PL2:
            begin
                nwr_addr = n_reg;
                nwe      = '{we_next: 1'b1, we_prev: 1'b1, we_item: 1'b1};
                nwd_next = nd_next;
                nwd_prev = a_reg;
            end
            S_PL3:
            begin
                nwr_addr    = AW'(b_reg);
                nwe.we_prev = 1'b1;
                nwd_prev    = PW'(n_reg);
            end
            S_PL4:
            begin
                nwr_addr    = AW'(a_reg);
                nwe.we_next = 1'b1;
                nwd_next    = PW'(n_reg);
            end
            S_UL1:
            begin
                nwr_addr    = AW'(nd_prev);
                nwe.we_next = 1'b1;
                nwd_next    = nd_next;
            end
            S_UL2:
            begin
                nwr_addr    = AW'(b_reg);
                nwe.we_prev = 1'b1;
                nwd_prev    = a_reg;
            end
            S_UL3, S_CC6:
            begin
                nwr_addr    = n_reg;
                nwe.we_next = 1'b1;
                nwd_next    = ft_reg;
                if (state_reg == S_CC6)
                begin
                    lnk_we    = (l2_reg != '0);
                    lnk_waddr = l2_reg;
                end
            end
            S_CC1:
            begin
                nrd_addr = t_reg;
            end
            S_CC2:
            begin
                nrd_addr = n_reg;
            end
            S_CC3:
            begin
                nwr_addr    = AW'(nd_next);
                nwe.we_prev = 1'b1;
                nwd_prev    = a_reg;
            end
            S_CC4:
            begin
                nwr_addr    = AW'(a_reg);
                nwe.we_next = 1'b1;
                nwd_next    = b_reg;
            end
            S_CC5:
            begin
                nwr_addr    = t_reg;
                nwe.we_next = 1'b1;
                nwd_next    = ft_reg;
            end
            S_CR2:
            begin
                nwr_addr    = h_reg;
                nwe.we_next = 1'b1;
                nwd_next    = PW'(t_reg);
            end
            S_CR3:
            begin
                nwr_addr    = t_reg;
                nwe.we_next = 1'b1;
                nwe.we_prev = 1'b1;
                nwd_next    = NIL_N;
                nwd_prev    = PW'(h_reg);
            end
            default:
            begin
                nrd_addr = c_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ft_reg    <= '0;
            wm_reg    <= '0;
            flt_reg   <= LP'(1);
            lwm_reg   <= LP'(1);
            used_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ft_reg    <= ft_next;
            wm_reg    <= wm_next;
            flt_reg   <= flt_next;
            lwm_reg   <= lwm_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        l_reg     <= l_next;
        l2_reg    <= l2_next;
        ladr_reg  <= ladr_next;
        made_reg  <= made_next;
        v_reg     <= v_next;
        item_reg  <= item_next;
        h_reg     <= h_next;
        t_reg     <= t_next;
        c_reg     <= c_next;
        n_reg     <= n_next;
        t2_reg    <= t2_next;
        len_reg   <= len_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        st_reg    <= st_next;
        wlt_reg   <= wlt_next;
        lnk_reg   <= lnk_next;
        ostat_reg <= ostat_next;
        oitem_reg <= oitem_next;
        onew_reg  <= onew_next;
        ocnt_reg  <= ocnt_next;
    end

    assign out_valid  = ov_reg;
    assign status     = ostat_reg;
    assign item_out   = oitem_reg;
    assign new_list   = onew_reg;
    assign item_count = ocnt_reg;

`ifndef ASSERT_OFF
    a_fill_mark_grows: assert property (@(posedge clk) disable iff (!rst_n)
        wm_reg >= $past(wm_reg))
        else $error("node fill mark moved back");

    a_list0_not_stacked: assert property (@(posedge clk) disable iff (!rst_n)
        flt_reg != '0)
        else $error("list 0 on the free list stack");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_LOAD)
        else $error("accepted transaction not started");
`endif

endmodule

// ===== src/pmlm_node_mem.sv =====
// Node pool memory: next, prev and item fields with fill-mark view of untouched nodes.
module pmlm_node_mem #(
    parameter int NUM_NODES = pmlm_pkg::DEF_NUM_NODES,
    parameter int ITEM_BITS = pmlm_pkg::DEF_ITEM_BITS
) (
    input  logic                               clk,
    input  logic [$clog2(NUM_NODES)-1:0]       rd_addr,
    input  logic [$clog2(NUM_NODES+1)-1:0]     fill_mark,
    input  pmlm_pkg::node_we_t                 we,
    input  logic [$clog2(NUM_NODES)-1:0]       wr_addr,
    input  logic [$clog2(NUM_NODES+1)-1:0]     wr_next,
    input  logic [$clog2(NUM_NODES+1)-1:0]     wr_prev,
    input  logic [ITEM_BITS-1:0]               wr_item,
    output logic [$clog2(NUM_NODES+1)-1:0]     rd_next,
    output logic [$clog2(NUM_NODES+1)-1:0]     rd_prev,
    output logic [ITEM_BITS-1:0]               rd_item
);
    import pmlm_pkg::*;

    localparam int AW = $clog2(NUM_NODES);
    localparam int PW = $clog2(NUM_NODES+1);

    logic [PW-1:0]        next_mem [NUM_NODES];
    logic [PW-1:0]        prev_mem [NUM_NODES];
    logic [ITEM_BITS-1:0] item_mem [NUM_NODES];

    logic [PW-1:0]        next_q;
    logic [AW-1:0]        addr_q;
    logic                 fresh_q;

    always_ff @(posedge clk)
    begin
        if (we.we_next)
        begin
            next_mem[wr_addr] <= wr_next;
        end
        if (we.we_prev)
        begin
            prev_mem[wr_addr] <= wr_prev;
        end
        if (we.we_item)
        begin
            item_mem[wr_addr] <= wr_item;
        end
        next_q  <= next_mem[rd_addr];
        rd_prev <= prev_mem[rd_addr];
        rd_item <= item_mem[rd_addr];
        addr_q  <= rd_addr;
        fresh_q <= PW'(rd_addr) >= fill_mark;
    end

    // nodes at or above the fill mark still hold their reset chain
    assign rd_next = fresh_q ? PW'(addr_q) + PW'(1) : next_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for pooled_multi_list_manager_unit: directed table plus random commands.
`timescale 1ns / 1ps

module tb;
    import pmlm_pkg::*;

    localparam int NL      = DEF_NUM_LISTS;
    localparam int NN      = DEF_NUM_NODES;
    localparam int NIL     = NN;
    localparam int WD_MAX  = 5000;
    localparam int HOLD_CY = 300;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] item;
        logic [3:0]  nl;
        logic [8:0]  cnt;
    } list_result_t;

    typedef struct {
        cmd_t         op;
        int           l;
        int           l2;
        logic [31:0]  v;
        bit           typed;
        list_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  cmd;
    logic [3:0]  list_sel;
    logic [3:0]  second_list;
    logic [31:0] item_value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] item_out;
    logic [3:0]  new_list;
    logic [8:0]  item_count;

    pooled_multi_list_manager_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .list_sel(list_sel), .second_list(second_list), .item_value(item_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .item_out(item_out), .new_list(new_list), .item_count(item_count)
    );

    // shadow of the list manager
    int          nnext [NN+1];
    int          nprev [NN+1];
    logic [31:0] nitem [NN+1];
    int          free_top;
    int          hsent [NL];
    int          tsent [NL];
    int          cur   [NL];
    int          len   [NL];
    bit          used  [NL];
    int          flink [NL];
    int          flist_top;

    list_result_t pending_results[$];
    int  errors;
    int  checked;
    int  full_hits;
    int  sent;
    bit  calm;
    bit  hold_req;
    int  hold_left;
    int  stall_left;
    int  idle_cycles;

    function automatic int cl(int i);
        return i < NIL ? i : NIL;
    endfunction

    function automatic bit nodes_avail(int need);
        if (free_top >= NIL) return 0;
        if (need > 1 && nnext[cl(free_top)] >= NIL) return 0;
        return 1;
    endfunction

    function automatic int pop_node();
        int n;
        n = cl(free_top);
        free_top = nnext[n];
        return n;
    endfunction

    function automatic void push_node(int n);
        n = cl(n);
        nnext[n] = free_top;
        free_top = n;
    endfunction

    function automatic void link_after(int a, int n);
        int b;
        a = cl(a);
        n = cl(n);
        b = nnext[a];
        nnext[n] = b;
        nprev[cl(b)] = n;
        nnext[a] = n;
        nprev[n] = a;
    endfunction

    function automatic logic [1:0] place_item(int l, int pos, logic [31:0] v,
                                              output logic [31:0] item);
        int n;
        item = '0;
        if (!nodes_avail(1)) return STAT_FULL;
        n = pop_node();
        nitem[n] = v;
        link_after(pos, n);
        len[l]++;
        cur[l] = n;
        item = v;
        return STAT_OK;
    endfunction

    function automatic logic [31:0] unlink_node(int l, int n);
        int p;
        int q;
        n = cl(n);
        p = nprev[n];
        q = nnext[n];
        nnext[cl(p)] = q;
        nprev[cl(q)] = p;
        push_node(n);
        len[l]--;
        return nitem[n];
    endfunction

    function automatic void reset_lists();
        for (int i = 0; i <= NN; i++) begin
            nnext[i] = (i + 1 < NN) ? i + 1 : NIL;
            nprev[i] = 0;
            nitem[i] = '0;
        end
        free_top = 0;
        for (int i = 0; i < NL; i++) begin
            hsent[i] = 0; tsent[i] = 0; cur[i] = 0; len[i] = 0;
            used[i] = 0; flink[i] = i + 1;
        end
        flist_top = 1;
    endfunction

    function automatic list_result_t apply_list_cmd(cmd_t op, int l, int l2, logic [31:0] v);
        list_result_t r;
        logic [1:0]   st;
        logic [31:0]  item;
        int           made;
        bit           ok;
        bit           hit;
        int h, t, c, nl, h2, t2, last1, first2, last;
        st = STAT_MISS; item = '0; made = 0;
        ok = used[l];
        h = 0; t = 0; c = 0;
        if (ok) begin
            h = cl(hsent[l]); t = cl(tsent[l]); c = cl(cur[l]);
        end
        if (op == CMD_CREATE) begin
            nl = NL;
            if (!used[0]) nl = 0;
            else if (flist_top < NL) nl = flist_top;
            if (nl >= NL || !nodes_avail(2)) st = STAT_FULL;
            else begin
                if (nl != 0) flist_top = flink[nl];
                h = pop_node();
                t = pop_node();
                nnext[h] = t; nprev[t] = h; nnext[t] = NIL;
                hsent[nl] = h; tsent[nl] = t; cur[nl] = h;
                len[nl] = 0; used[nl] = 1;
                made = nl;
                st = STAT_OK;
            end
        end else if (ok) begin
            case (op)
                CMD_COUNT: st = STAT_OK;
                CMD_FIRST, CMD_LAST: begin
                    if (len[l] == 0) cur[l] = h;
                    else begin
                        c = (op == CMD_FIRST) ? nnext[h] : nprev[t];
                        cur[l] = c; item = nitem[cl(c)]; st = STAT_OK;
                    end
                end
                CMD_NEXT: begin
                    if (c == t || c == nprev[t]) cur[l] = t;
                    else begin
                        c = nnext[c]; cur[l] = c; item = nitem[cl(c)]; st = STAT_OK;
                    end
                end
                CMD_PREV: begin
                    if (c == h || c == nnext[h]) cur[l] = h;
                    else begin
                        c = nprev[c]; cur[l] = c; item = nitem[cl(c)]; st = STAT_OK;
                    end
                end
                CMD_CURR: if (c != h && c != t) begin
                    item = nitem[c]; st = STAT_OK;
                end
                CMD_ADD:     st = place_item(l, c == t ? nprev[t] : c, v, item);
                CMD_INSERT:  st = place_item(l, c == h ? h : (c == t ? nprev[t] : nprev[c]),
                                             v, item);
                CMD_APPEND:  st = place_item(l, nprev[t], v, item);
                CMD_PREPEND: st = place_item(l, h, v, item);
                CMD_REMOVE: if (len[l] != 0 && c != h && c != t) begin
                    cur[l] = nnext[c];
                    item = unlink_node(l, c);
                    st = STAT_OK;
                end
                CMD_CONCAT: if (l2 != l && used[l2]) begin
                    h2 = cl(hsent[l2]); t2 = cl(tsent[l2]);
                    last1 = cl(nprev[t]);
                    first2 = nnext[h2];
                    nprev[cl(first2)] = last1;
                    nnext[last1] = first2;
                    tsent[l] = t2;
                    if (c == t) cur[l] = t2;
                    push_node(t);
                    push_node(h2);
                    len[l] += len[l2];
                    len[l2] = 0;
                    used[l2] = 0;
                    if (l2 != 0) begin
                        flink[l2] = flist_top; flist_top = l2;
                    end
                    st = STAT_OK;
                end
                CMD_FREE: begin
                    nnext[t] = free_top;
                    free_top = h;
                    len[l] = 0;
                    used[l] = 0;
                    if (l != 0) begin
                        flink[l] = flist_top; flist_top = l;
                    end
                    st = STAT_OK;
                end
                CMD_TRIM: if (len[l] != 0) begin
                    last = cl(nprev[t]);
                    cur[l] = nprev[last];
                    item = unlink_node(l, last);
                    st = STAT_OK;
                end
                default: if (len[l] != 0 && c != t) begin
                    hit = 0;
                    if (c != h && nitem[c] == v) hit = 1;
                    while (!hit && nnext[c] != t && nnext[c] < NIL) begin
                        c = nnext[c];
                        if (nitem[c] == v) hit = 1;
                    end
                    if (hit) begin
                        cur[l] = c; item = nitem[c]; st = STAT_OK;
                    end else cur[l] = t;
                end
            endcase
        end
        if (st != STAT_OK) item = '0;
        r.st   = st;
        r.item = item;
        r.nl   = made[3:0];
        r.cnt  = (op != CMD_CREATE && used[l]) ? len[l][8:0] : 9'd0;
        return r;
    endfunction

    task automatic send_cmd(cmd_t op, int l, int l2, logic [31:0] v,
                            bit typed, list_result_t typed_res);
        list_result_t r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        list_sel    <= l[3:0];
        second_list <= l2[3:0];
        item_value  <= v;
        do @(posedge clk); while (!in_ready);
        r = apply_list_cmd(op, l, l2, v);
        pending_results.push_back(typed ? typed_res : r);
        sent++;
    endtask

    function automatic int pick_list();
        int cand[$];
        for (int i = 0; i < NL; i++) if (used[i]) cand.push_back(i);
        if (cand.size() > 0 && $urandom_range(0, 9) < 8)
            return cand[$urandom_range(0, cand.size() - 1)];
        return $urandom_range(0, NL - 1);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(0, 7);
        if (r == 5) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        return $urandom;
    endfunction

    // mode 0 mixed, 1 fill, 2 drain
    function automatic cmd_t pick_cmd(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 1) begin
            if (r < 12) return CMD_CREATE;
            if (r < 75) return cmd_t'(CMD_ADD + $urandom_range(0, 3));
            if (r < 90) return cmd_t'(CMD_FIRST + $urandom_range(0, 4));
            return CMD_SEARCH;
        end
        if (mode == 2) begin
            if (r < 10) return CMD_FREE;
            if (r < 20) return CMD_CONCAT;
            if (r < 60) return $urandom_range(0, 1) ? CMD_REMOVE : CMD_TRIM;
            if (r < 85) return cmd_t'(CMD_FIRST + $urandom_range(0, 4));
            return CMD_SEARCH;
        end
        if (r < 7)  return CMD_CREATE;
        if (r < 11) return CMD_FREE;
        if (r < 16) return CMD_CONCAT;
        if (r < 42) return cmd_t'(CMD_ADD + $urandom_range(0, 3));
        if (r < 62) return cmd_t'(CMD_FIRST + $urandom_range(0, 3));
        if (r < 70) return $urandom_range(0, 1) ? CMD_CURR : CMD_COUNT;
        if (r < 82) return $urandom_range(0, 1) ? CMD_REMOVE : CMD_TRIM;
        return CMD_SEARCH;
    endfunction

    task automatic run_random(int n, int mode);
        list_result_t dummy;
        dummy = '0;
        repeat (n) send_cmd(pick_cmd(mode), pick_list(), pick_list(), pick_value(), 0, dummy);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result checker and output-side throttling
    always @(posedge clk) begin
        list_result_t e;
        if (rst_n && out_valid && out_ready) begin
            checked++;
            if (status == STAT_FULL) full_hits++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d item=%h", $time, status, item_out);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (status !== e.st) begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, status);
                    errors++;
                end
                if (item_out !== e.item) begin
                    $display("%0t: item_out exp %h got %h", $time, e.item, item_out);
                    errors++;
                end
                if (new_list !== e.nl) begin
                    $display("%0t: new_list exp %0d got %0d", $time, e.nl, new_list);
                    errors++;
                end
                if (item_count !== e.cnt) begin
                    $display("%0t: item_count exp %0d got %0d", $time, e.cnt, item_count);
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CY - 1;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WD_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, WD_MAX);
            $display("** pooled_multi_list_manager_unit: FAILED **");
            $finish;
        end
    end

    function automatic list_result_t mk(logic [1:0] st, logic [31:0] item, int nl, int cnt);
        list_result_t r;
        r.st = st; r.item = item; r.nl = nl[3:0]; r.cnt = cnt[8:0];
        return r;
    endfunction

    initial begin
        stim_row_t rows[$];
        list_result_t none;
        none = '0;
        clk = 1'b0; rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0;
        cmd = '0; list_sel = '0; second_list = '0; item_value = '0;
        errors = 0; checked = 0; full_hits = 0; sent = 0;
        calm = 0; hold_req = 0; hold_left = 0; stall_left = 0; idle_cycles = 0;
        reset_lists();

        rows = '{
            '{CMD_COUNT,   3, 0, 32'h0,         1, mk(STAT_MISS, 0, 0, 0)},
            '{CMD_CREATE,  9, 4, 32'h0,         1, mk(STAT_OK, 0, 0, 0)},
            '{CMD_FIRST,   0, 0, 32'h0,         1, mk(STAT_MISS, 0, 0, 0)},
            '{CMD_CREATE,  0, 0, 32'h0,         1, mk(STAT_OK, 0, 1, 0)},
            '{CMD_APPEND,  0, 0, 32'hFFFF_FFFF, 1, mk(STAT_OK, 32'hFFFF_FFFF, 0, 1)},
            '{CMD_PREPEND, 0, 0, 32'h0,         1, mk(STAT_OK, 0, 0, 2)},
            '{CMD_ADD,     0, 0, 32'hA5A5_A5A5, 0, none},
            '{CMD_INSERT,  0, 0, 32'h5A5A_5A5A, 0, none},
            '{CMD_CURR,    0, 0, 32'h0,         0, none},
            '{CMD_NEXT,    0, 0, 32'h0,         0, none},
            '{CMD_NEXT,    0, 0, 32'h0,         0, none},
            '{CMD_NEXT,    0, 0, 32'h0,         0, none},
            '{CMD_PREV,    0, 0, 32'h0,         0, none},
            '{CMD_LAST,    0, 0, 32'h0,         0, none},
            '{CMD_SEARCH,  0, 0, 32'h0,         0, none},
            '{CMD_SEARCH,  0, 0, 32'h0001_2345, 0, none},
            '{CMD_SEARCH,  0, 0, 32'hFFFF_FFFF, 0, none},
            '{CMD_REMOVE,  0, 0, 32'h0,         0, none},
            '{CMD_FIRST,   0, 0, 32'h0,         0, none},
            '{CMD_REMOVE,  0, 15, 32'h0,        0, none},
            '{CMD_TRIM,    1, 0, 32'h0,         1, mk(STAT_MISS, 0, 0, 0)},
            '{CMD_CONCAT,  0, 0, 32'h0,         0, none},
            '{CMD_CONCAT,  0, 1, 32'h0,         0, none},
            '{CMD_FREE,    0, 0, 32'h0,         1, mk(STAT_OK, 0, 0, 0)},
            '{CMD_CURR,    1, 0, 32'h0,         1, mk(STAT_MISS, 0, 0, 0)}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_cmd(rows[i].op, rows[i].l, rows[i].l2, rows[i].v, rows[i].typed, rows[i].res);

        run_random(200, 0);
        hold_req = 1'b1;
        run_random(150, 1);
        wait_drained();
        run_random(100, 2);
        run_random(150, 0);
        calm = 1'b1;
        run_random(100, 0);
        in_valid <= 1'b0;

        while (pending_results.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d commands (25 directed, rest random in fill/drain/mixed phases).", sent);
        $display("Checked %0d results, %0d of them out-of-resource.", checked, full_hits);
        if (errors == 0)
            $display("** pooled_multi_list_manager_unit: PASSED **");
        else
            $display("** pooled_multi_list_manager_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
src/pmlm_pkg.sv
src/pmlm_node_mem.sv
src/pooled_multi_list_manager_unit.sv
tb/tb.sv
